// ===== sv/ipc_pkg.sv =====
// Shared types and constants for the IPv4 text parser and classifier.
`timescale 1ns / 1ps

package ipc_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned ADDR_W    = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [ADDR_W-1:0]    t_addr;

    // Configuration register indexes
    localparam t_cfg_idx REG_REF_ADDRESS = t_cfg_idx'(0);
    localparam t_cfg_idx REG_SUBNET_MASK = t_cfg_idx'(1);

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;

    // Address ranges
    localparam t_addr MASK_8   = 32'hFF00_0000;
    localparam t_addr NET_10   = 32'h0A00_0000;
    localparam t_addr MASK_12  = 32'hFFF0_0000;
    localparam t_addr NET_172  = 32'hAC10_0000;
    localparam t_addr MASK_16  = 32'hFFFF_0000;
    localparam t_addr NET_192  = 32'hC0A8_0000;
    localparam t_addr NET_169  = 32'hA9FE_0000;
    localparam logic [7:0] OCTET_LOOPBACK = 8'd127;
    localparam logic [9:0] OCTET_MAX      = 10'd255;

    typedef struct packed {
        t_addr address;
        logic  ipv4_valid;
        logic  loopback;
        logic  private_range;
        logic  link_local;
        logic  same_subnet;
    } t_result;

endpackage

// ===== sv/ipc_ifs.sv =====
// Handshake interfaces for the character, result and configuration channels.
`timescale 1ns / 1ps

interface ipc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface ipc_out_if import ipc_pkg::*; ;
    logic  valid;
    logic  ready;
    t_addr address;
    logic  ipv4_valid;
    logic  loopback;
    logic  private_range;
    logic  link_local;
    logic  same_subnet;

    modport source (output valid, output address, output ipv4_valid, output loopback,
                    output private_range, output link_local, output same_subnet,
                    input ready);
    modport sink   (input valid, input address, input ipv4_valid, input loopback,
                    input private_range, input link_local, input same_subnet,
                    output ready);
endinterface

interface ipc_cfg_if import ipc_pkg::*; ;
    logic     valid;
    logic     ready;
    t_cfg_idx reg_index;
    t_addr    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== sv/ipv4_text_parse_classify_top.sv =====
// Top level: IPv4 dotted-quad text parser with address classification.
`timescale 1ns / 1ps

// Takes one ASCII character per transfer on i_in, one character every clock cycle
// with no gaps needed; the per-character work is a multiply-by-ten accumulate and a
// few compares, done in the cycle the character is transferred. The character
// flagged last_char closes the string: its result (address, ipv4_valid and the
// loopback, private, link-local and same-subnet flags) is registered and shown on
// o_out the cycle after if the output register is free, and the parse state
// returns to empty so the next character starts a new string. Other characters
// give no result. A result register plus a one-entry skid register sit on the
// output, so characters keep flowing while a result waits; i_in.ready drops only
// when both hold results. reference_address (index 0) and subnet_mask (index 1)
// are written on i_cfg, which is always ready; writes to other indexes are
// dropped. Write them only while no string is in progress and no result is pending.
module ipv4_text_parse_classify_top
    import ipc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipc_in_if.sink        i_in,
    ipc_out_if.source     o_out,
    ipc_cfg_if.sink       i_cfg
);

    // configuration
    t_addr r_ref_addr;
    t_addr r_mask;

    // per-string parse state
    logic [9:0]  r_acc;
    logic [1:0]  r_digits;
    logic [1:0]  r_dots;
    logic [23:0] r_upper;
    logic        r_err;
    logic [1:0]  r_pos;
    logic        r_v6lb;
    logic        r_v6ll;

    logic [9:0]  n_acc;
    logic [1:0]  n_digits;
    logic [1:0]  n_dots;
    logic [23:0] n_upper;
    logic        n_err;
    logic [1:0]  n_pos;
    logic        n_v6lb;
    logic        n_v6ll;

    // output register and skid entry
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic       in_fire;
    logic       res_fire;
    logic       out_free;
    logic [7:0] ch;
    logic [7:0] lc;
    logic       is_digit;
    logic       is_dot;
    logic       lb_ok;
    logic       ll_ok;
    logic       valid;
    t_addr      addr;
    t_result    result;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign res_fire    = in_fire && i_in.last_char;
    assign out_free    = !r_out_valid || o_out.ready;

    assign ch       = i_in.character;
    assign lc       = (ch >= CH_UC_A && ch <= CH_UC_Z) ? (ch | 8'h20) : ch;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_dot   = (ch == CH_DOT);

    // text prefix checks against "::1" and "fe8".."feb"
    always_comb begin
        case (r_pos)
            2'd0: begin
                lb_ok = (ch == CH_COLON);
                ll_ok = (lc == CH_F);
            end
            2'd1: begin
                lb_ok = (ch == CH_COLON);
                ll_ok = (lc == CH_E);
            end
            2'd2: begin
                lb_ok = (ch == CH_ONE);
                ll_ok = (lc == CH_8) || (lc == CH_9) || (lc == CH_A) || (lc == CH_B);
            end
            default: begin
                lb_ok = 1'b0;
                ll_ok = 1'b1;
            end
        endcase
    end

    // dotted-quad step
    always_comb begin
        n_acc    = r_acc;
        n_digits = r_digits;
        n_dots   = r_dots;
        n_upper  = r_upper;
        n_err    = r_err;
        if (is_digit) begin
            if (r_digits == 2'd3) begin
                n_err = 1'b1;
            end else begin
                // acc*10 + digit, kept to 10 bits
                n_acc    = 10'({r_acc[6:0], 3'b000} + {r_acc[8:0], 1'b0} + {6'b0, ch[3:0]});
                n_digits = r_digits + 2'd1;
            end
        end else if (is_dot) begin
            if (r_digits == 2'd0 || r_acc > OCTET_MAX || r_dots == 2'd3) begin
                n_err = 1'b1;
            end else begin
                n_upper  = {r_upper[15:0], r_acc[7:0]};
                n_dots   = r_dots + 2'd1;
                n_acc    = '0;
                n_digits = '0;
            end
        end else begin
            n_err = 1'b1;
        end
        n_v6lb = r_v6lb && lb_ok;
        n_v6ll = r_v6ll && ll_ok;
        n_pos  = (r_pos == 2'd3) ? r_pos : r_pos + 2'd1;
    end

    // classification of the closing character
    assign valid = !n_err && (n_dots == 2'd3) && (n_digits != 2'd0) && (n_acc <= OCTET_MAX);
    assign addr  = valid ? {n_upper, n_acc[7:0]} : '0;

    always_comb begin
        result.address    = addr;
        result.ipv4_valid = valid;
        if (valid) begin
            result.loopback      = (addr[31:24] == OCTET_LOOPBACK);
            result.private_range = ((addr & MASK_8)  == NET_10)
                                || ((addr & MASK_12) == NET_172)
                                || ((addr & MASK_16) == NET_192);
            result.link_local    = ((addr & MASK_16) == NET_169);
            result.same_subnet   = (((addr ^ r_ref_addr) & r_mask) == '0);
        end else begin
            result.loopback      = n_v6lb && (r_pos == 2'd2);
            result.private_range = 1'b0;
            result.link_local    = n_v6ll && r_pos[1];
            result.same_subnet   = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_addr <= '0;
            r_mask     <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                REG_REF_ADDRESS: r_ref_addr <= i_cfg.wr_data;
                REG_SUBNET_MASK: r_mask     <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // parse state: cleared after the closing character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || res_fire) begin
            r_acc    <= '0;
            r_digits <= '0;
            r_dots   <= '0;
            r_upper  <= '0;
            r_err    <= 1'b0;
            r_pos    <= '0;
            r_v6lb   <= 1'b1;
            r_v6ll   <= 1'b1;
        end else if (in_fire) begin
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_dots   <= n_dots;
            r_upper  <= n_upper;
            r_err    <= n_err;
            r_pos    <= n_pos;
            r_v6lb   <= n_v6lb;
            r_v6ll   <= n_v6ll;
        end
    end

    // result register with skid entry; skid always holds the younger result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_fire;
            end else begin
                r_out_valid  <= res_fire;
            end
        end else if (res_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (res_fire) begin
                    r_skid <= result;
                end
            end else if (res_fire) begin
                r_out <= result;
            end
        end else if (res_fire) begin
            r_skid <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.address       = r_out.address;
    assign o_out.ipv4_valid    = r_out.ipv4_valid;
    assign o_out.loopback      = r_out.loopback;
    assign o_out.private_range = r_out.private_range;
    assign o_out.link_local    = r_out.link_local;
    assign o_out.same_subnet   = r_out.same_subnet;

endmodule

// ===== sv/ipc_checker.sv =====
// Port-level checks for the IPv4 text parser, bound to the top level.
`timescale 1ns / 1ps

module ipc_checker
    import ipc_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_addr i_address,
    input logic  i_ipv4_valid,
    input logic  i_private_range,
    input logic  i_same_subnet
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown after reset");

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_address))
        else $error("stalled result changed");

    // invalid text gives a zero address and no address-based flags
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ipv4_valid |-> i_address == '0 && !i_private_range
                                          && !i_same_subnet)
        else $error("invalid string carries address data");

    // input backpressure only while results are pending
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with output empty");

endmodule

bind ipv4_text_parse_classify_top ipc_checker u_ipc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_address       (o_out.address),
    .i_ipv4_valid    (o_out.ipv4_valid),
    .i_private_range (o_out.private_range),
    .i_same_subnet   (o_out.same_subnet)
);

// ===== test/ipv4_text_parse_classify_checker.sv =====
// Checker for the IPv4 text parser: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps

module ipv4_text_parse_classify_checker
    import ipc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ipc_in_if    i_in,
    ipc_out_if   i_out,
    ipc_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam logic [1:0] MAX_DIGITS    = 2'd3;
    localparam logic [1:0] DOTS_IN_QUAD  = 2'd3;
    localparam logic [1:0] POS_SATURATED = 2'd3;
    localparam logic [1:0] POS_THIRD     = 2'd2;

    // shadow of the parse state and registers
    logic [9:0]  grp_value;
    logic [1:0]  grp_digits;
    logic [1:0]  dots_seen;
    logic [23:0] closed_octets;
    logic        bad_text;
    logic [1:0]  text_pos;
    logic        colon_one_ok;
    logic        fe_prefix_ok;
    t_addr       ref_addr;
    t_addr       subnet;

    t_result     awaited_classes[$];
    int          mismatches;

    function automatic void clear_text();
        grp_value     = '0;
        grp_digits    = '0;
        dots_seen     = '0;
        closed_octets = '0;
        bad_text      = 1'b0;
        text_pos      = '0;
        colon_one_ok  = 1'b1;
        fe_prefix_ok  = 1'b1;
    endfunction

    // Folds one character into the shadow state; returns 1 with the classified
    // address when the character closes the string.
    function automatic logic absorb_char(input logic [7:0] ch, input logic is_last,
                                         output t_result res);
        logic [7:0] lc;
        logic [1:0] pos;
        logic       lb_ok;
        logic       ll_ok;
        logic       quad_ok;
        t_addr      addr;
        res = '0;
        pos = text_pos;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (grp_digits == MAX_DIGITS) begin
                bad_text = 1'b1;
            end else begin
                grp_value  = 10'(grp_value * 10 + (ch - CH_ZERO));
                grp_digits = grp_digits + 2'd1;
            end
        end else if (ch == CH_DOT) begin
            if (grp_digits == '0 || grp_value > OCTET_MAX || dots_seen == DOTS_IN_QUAD) begin
                bad_text = 1'b1;
            end else begin
                closed_octets = {closed_octets[15:0], grp_value[7:0]};
                dots_seen     = dots_seen + 2'd1;
                grp_value     = '0;
                grp_digits    = '0;
            end
        end else begin
            bad_text = 1'b1;
        end

        // text tests for ::1 and fe8..feb
        lc = (ch >= CH_UC_A && ch <= CH_UC_Z) ? ch + (CH_A - CH_UC_A) : ch;
        case (pos)
            2'd0, 2'd1: lb_ok = (ch == CH_COLON);
            2'd2:       lb_ok = (ch == CH_ONE);
            default:    lb_ok = 1'b0;
        endcase
        case (pos)
            2'd0:    ll_ok = (lc == CH_F);
            2'd1:    ll_ok = (lc == CH_E);
            2'd2:    ll_ok = (lc == CH_8 || lc == CH_9 || lc == CH_A || lc == CH_B);
            default: ll_ok = 1'b1;
        endcase
        colon_one_ok = colon_one_ok && lb_ok;
        fe_prefix_ok = fe_prefix_ok && ll_ok;
        if (text_pos != POS_SATURATED) text_pos = text_pos + 2'd1;

        if (!is_last) return 1'b0;

        quad_ok = !bad_text && dots_seen == DOTS_IN_QUAD && grp_digits != '0 &&
                  grp_value <= OCTET_MAX;
        addr = quad_ok ? {closed_octets, grp_value[7:0]} : '0;
        res.address    = addr;
        res.ipv4_valid = quad_ok;
        if (quad_ok) begin
            res.loopback      = (addr[31:24] == OCTET_LOOPBACK);
            res.private_range = (addr & MASK_8) == NET_10 || (addr & MASK_12) == NET_172 ||
                                (addr & MASK_16) == NET_192;
            res.link_local    = (addr & MASK_16) == NET_169;
            res.same_subnet   = ((addr ^ ref_addr) & subnet) == '0;
        end else begin
            res.loopback      = colon_one_ok && pos == POS_THIRD;
            res.private_range = 1'b0;
            res.link_local    = fe_prefix_ok && pos >= POS_THIRD;
            res.same_subnet   = 1'b0;
        end
        clear_text();
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    initial mismatches = 0;

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            clear_text();
            ref_addr = '0;
            subnet   = '0;
            awaited_classes.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (awaited_classes.size() == 0) begin
                    $display("%0t: result with none awaited: address %h flags %b%b%b%b%b",
                             $time, i_out.address, i_out.ipv4_valid, i_out.loopback,
                             i_out.private_range, i_out.link_local, i_out.same_subnet);
                    mismatches++;
                end else begin
                    want = awaited_classes.pop_front();
                    check_field("address", want.address, i_out.address);
                    check_field("ipv4_valid", want.ipv4_valid, i_out.ipv4_valid);
                    check_field("loopback", want.loopback, i_out.loopback);
                    check_field("private_range", want.private_range, i_out.private_range);
                    check_field("link_local", want.link_local, i_out.link_local);
                    check_field("same_subnet", want.same_subnet, i_out.same_subnet);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.reg_index == REG_REF_ADDRESS) ref_addr = i_cfg.wr_data;
                else if (i_cfg.reg_index == REG_SUBNET_MASK) subnet = i_cfg.wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                if (absorb_char(i_in.character, i_in.last_char, fresh))
                    awaited_classes.insert(awaited_classes.size(), fresh);
            end
        end
        o_outstanding <= awaited_classes.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ===== test/ipv4_text_parse_classify_top_tb.sv =====
// Testbench top for the IPv4 text parser: stimulus, back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module ipv4_text_parse_classify_top_tb;
    import ipc_pkg::*;

    typedef logic [7:0] t_char;

    // ways of spoiling a well-formed dotted quad
    typedef enum int {
        FLAW_NONE,
        FLAW_BIG_GROUP,
        FLAW_LONG_GROUP,
        FLAW_MISSING_GROUP,
        FLAW_EXTRA_GROUP,
        FLAW_EMPTY_GROUP,
        FLAW_STRAY_BYTE,
        FLAW_COLON
    } t_flaw;

    localparam int       CLK_PERIOD       = 12;
    localparam int       RESET_CYCLES     = 12;
    localparam int       QUIET_LIMIT      = 2000;  // cycles without any transfer
    localparam int       DRAIN_CYCLES     = 4;     // extra wait once every awaited result is out
    localparam int       PHASE_CHARS      = 150;
    localparam int       NUM_PHASES       = 4;
    localparam t_cfg_idx REG_FIRST_UNUSED = REG_SUBNET_MASK + t_cfg_idx'(1);
    localparam t_cfg_idx REG_LAST_INDEX   = '1;
    localparam t_char    CASE_GAP         = CH_A - CH_UC_A;
    localparam t_char    FE_THIRD [4]     = '{CH_8, CH_9, CH_A, CH_B};

    // idle/stall odds per phase, percent: none, sender, receiver, both lightly
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 76, 0, 9};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 76, 9};

    logic  clk;
    logic  rst_n;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    chars_sent;
    int    quiet_cycles;
    int    fail_total;
    int    awaited;
    t_addr net_ref;
    t_addr net_mask;

    ipc_in_if  in_ch ();
    ipc_out_if res_ch ();
    ipc_cfg_if cfg_ch ();

    ipv4_text_parse_classify_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    ipv4_text_parse_classify_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (res_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_total),
        .o_outstanding (awaited)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result side: ready is redrawn every cycle against the phase's stall odds.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles++;
            end
        end
    end

    function automatic int digits_needed(input int value);
        return (value >= 100) ? 3 : (value >= 10) ? 2 : 1;
    endfunction

    // decimal group, zero-padded to width; width 0 gives an empty group
    function automatic void put_group(ref t_char txt[$], input int value, input int width);
        int scale;
        scale = 1;
        for (int i = 1; i < width; i++) scale *= 10;
        for (int i = 0; i < width; i++) begin
            txt.insert(txt.size(), CH_ZERO + t_char'((value / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic t_char any_case(input t_char c);
        if (c >= CH_A && c <= CH_F && $urandom_range(1) == 1) return c - CASE_GAP;
        return c;
    endfunction

    // characters the parser has an opinion about, plus the odd arbitrary byte
    function automatic t_char noise_char();
        case ($urandom_range(4))
            0:       return CH_ZERO + t_char'($urandom_range(9));
            1:       return CH_DOT;
            2:       return CH_COLON;
            3:       return any_case(CH_A + t_char'($urandom_range(5)));
            default: return t_char'($urandom_range(255));
        endcase
    endfunction

    // Addresses biased towards the classified ranges and their neighbours,
    // and towards the subnet currently loaded.
    function automatic t_addr pick_address();
        t_addr r;
        r = $urandom;
        case ($urandom_range(7))
            0: return {OCTET_LOOPBACK, r[23:0]};
            1: return NET_10 | (r & ~MASK_8);
            2: return ($urandom_range(1) == 1) ? (NET_172 | (r & ~MASK_12))
                                               : {NET_172[31:24], r[23:0]};
            3: return ($urandom_range(1) == 1) ? (NET_192 | (r & ~MASK_16))
                                               : {NET_192[31:24], r[23:0]};
            4: return ($urandom_range(1) == 1) ? (NET_169 | (r & ~MASK_16))
                                               : {NET_169[31:24], r[23:0]};
            5: return (net_ref & net_mask) | (r & ~net_mask);
            6: return {{8{r[0]}}, {8{r[1]}}, {8{r[2]}}, {8{r[3]}}};
            default: return r;
        endcase
    endfunction

    // Mostly well-formed quads; the rest broken quads, ::1 / fe8..feb text
    // and loose bytes.
    function automatic void compose_text(ref t_char txt[$]);
        int    vals[$];
        int    widths[$];
        int    kind;
        int    idx;
        t_flaw flaw;
        t_addr a;
        txt.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            a = pick_address();
            for (int k = 0; k < 4; k++) begin
                vals.insert(vals.size(), int'(a[31 - 8 * k -: 8]));
                widths.insert(widths.size(),
                              ($urandom_range(3) == 0) ? $urandom_range(3, digits_needed(vals[k]))
                                                       : digits_needed(vals[k]));
            end
            flaw = (kind < 62) ? FLAW_NONE : t_flaw'($urandom_range(FLAW_COLON, FLAW_BIG_GROUP));
            idx  = $urandom_range(3);
            case (flaw)
                FLAW_BIG_GROUP: begin
                    vals[idx]   = $urandom_range(999, 256);
                    widths[idx] = 3;
                end
                FLAW_LONG_GROUP:    widths[idx] = 4;
                FLAW_MISSING_GROUP: begin
                    vals.delete(idx);
                    widths.delete(idx);
                end
                FLAW_EXTRA_GROUP: begin
                    vals.insert(idx, $urandom_range(255));
                    widths.insert(idx, 3);
                end
                FLAW_EMPTY_GROUP:   widths[idx] = 0;
                default: ;
            endcase
            for (int k = 0; k < vals.size(); k++) begin
                if (k > 0) txt.insert(txt.size(), CH_DOT);
                put_group(txt, vals[k], widths[k]);
            end
            if (flaw == FLAW_STRAY_BYTE)
                txt[$urandom_range(txt.size() - 1)] = t_char'($urandom_range(255));
            if (flaw == FLAW_COLON)
                txt.insert($urandom_range(txt.size()), CH_COLON);
        end else if (kind < 85) begin
            // ::1 exactly, with a tail, cut short or with one character spoilt
            txt = '{CH_COLON, CH_COLON, CH_ONE};
            case ($urandom_range(3))
                0: ;
                1: repeat ($urandom_range(3, 1)) txt.insert(txt.size(), noise_char());
                2: repeat ($urandom_range(2, 1)) void'(txt.pop_back());
                default: txt[$urandom_range(2)] = noise_char();
            endcase
        end else if (kind < 90) begin
            // fe8..feb in mixed case, near misses and short prefixes
            txt.insert(txt.size(), any_case(CH_F));
            txt.insert(txt.size(), any_case(CH_E));
            case ($urandom_range(3))
                0: txt.insert(txt.size(), any_case(FE_THIRD[$urandom_range(3)]));
                1: txt.insert(txt.size(), noise_char());
                2: ;
                default: txt[$urandom_range(1)] = noise_char();
            endcase
            if (txt.size() >= 3 && $urandom_range(1) == 1)
                repeat ($urandom_range(5, 1)) txt.insert(txt.size(), noise_char());
        end else begin
            repeat ($urandom_range(8, 1))
                txt.insert(txt.size(), ($urandom_range(1) == 1) ? noise_char()
                                                                : t_char'($urandom_range(255)));
        end
    endfunction

    // One string, one transfer per character; valid is only dropped for a
    // sender gap, never lowered and raised within one step.
    task automatic send_text(input t_char txt[$]);
        for (int i = 0; i < txt.size(); i++) begin
            while ($urandom_range(99) < sender_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.character <= txt[i];
            in_ch.last_char <= (i == txt.size() - 1);
            do @(posedge clk); while (in_ch.ready !== 1'b1);
            chars_sent++;
        end
    endtask

    // Wait for every awaited result, then give the block a few spare cycles.
    // The first edge lets the checker count a transfer from the current step.
    task automatic settle();
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reference then an unused index (must be dropped) then mask, with valid
    // held high across the three transfers.
    task automatic load_subnet(input t_addr ref_val, input t_addr mask_val);
        settle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= REG_REF_ADDRESS;
        cfg_ch.wr_data   <= ref_val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.reg_index <= t_cfg_idx'($urandom_range(REG_LAST_INDEX, REG_FIRST_UNUSED));
        cfg_ch.wr_data   <= $urandom;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.reg_index <= REG_SUBNET_MASK;
        cfg_ch.wr_data   <= mask_val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        net_ref  = ref_val;
        net_mask = mask_val;
    endtask

    initial begin
        t_char txt[$];
        in_ch.valid        <= 1'b0;
        in_ch.character    <= '0;
        in_ch.last_char    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= '0;
        cfg_ch.wr_data     <= '0;
        rst_n              <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        net_ref            = '0;
        net_mask           = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings under a 192.168/16 subnet: ::1, mixed-case feb,
        // a fourth digit, an empty group, lone bytes at both extremes and a
        // well-formed quad with octets 0 and 255.
        load_subnet(NET_192 | ($urandom & ~MASK_16), MASK_16);
        txt = '{CH_COLON, CH_COLON, CH_ONE};
        send_text(txt);
        txt = '{CH_F, CH_E - CASE_GAP, CH_B};
        send_text(txt);
        txt = '{CH_ONE, CH_ONE, CH_ONE, CH_ONE};
        send_text(txt);
        txt = '{CH_ONE, CH_DOT, CH_DOT, CH_ONE};
        send_text(txt);
        txt = '{t_char'('1)};
        send_text(txt);
        txt = '{t_char'('0)};
        send_text(txt);
        txt.delete();
        put_group(txt, 255, 3);
        txt.insert(txt.size(), CH_DOT);
        put_group(txt, 0, 1);
        txt.insert(txt.size(), CH_DOT);
        put_group(txt, 9, 1);
        txt.insert(txt.size(), CH_DOT);
        put_group(txt, 1, 1);
        send_text(txt);
        in_ch.valid <= 1'b0;

        // Random phases, each under its own subnet setting: all-ones, all-zeros,
        // a random prefix and a random scattered mask.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       load_subnet('1, '1);
                1:       load_subnet('0, '0);
                2:       load_subnet($urandom, ~(t_addr'('1) >> $urandom_range(32)));
                default: load_subnet($urandom, $urandom);
            endcase
            sender_idle_pct    = SEND_IDLE_PCT[p];
            receiver_stall_pct = RECV_STALL_PCT[p];
            chars_sent         = 0;
            while (chars_sent < PHASE_CHARS) begin
                compose_text(txt);
                send_text(txt);
            end
            in_ch.valid <= 1'b0;
        end

        receiver_stall_pct = 0;
        settle();
        if (fail_total == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
